/* rtl/npcm_pkg.sv */
// Shared types, constants and helper functions for the nearest palette color match block.
`timescale 1ns / 1ps

package npcm_pkg;

	// Table geometry
	localparam int DEPTH   = 256;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = 9;
	localparam int POS_W   = 5;
	localparam int PIX_W   = 32;
	localparam int COMP_W  = 8;
	localparam int DIST_W  = 10;
	localparam int INFL_W  = $clog2(DEPTH + 2);
	localparam int SLOT_W  = 8;

	// APB register map
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;
	localparam logic [1:0] REG_ENTRY_COUNT = 2'd0;
	localparam logic [1:0] REG_RED_POS     = 2'd1;
	localparam logic [1:0] REG_GREEN_POS   = 2'd2;
	localparam logic [1:0] REG_BLUE_POS    = 2'd3;

	// Request kinds carried on tuser
	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	// Largest distance code; any real distance (at most 765) is below it
	localparam logic [DIST_W-1:0] DIST_INIT = '1;

	typedef struct packed {
		logic [CNT_W-1:0] entry_count;
		logic [POS_W-1:0] red_position;
		logic [POS_W-1:0] green_position;
		logic [POS_W-1:0] blue_position;
	} cfg_t;

	// Lookup request as it walks down the cell chain
	typedef struct packed {
		logic [PIX_W-1:0]  pixel;
		logic [COMP_W-1:0] red;
		logic [COMP_W-1:0] green;
		logic [COMP_W-1:0] blue;
		logic [IDX_W-1:0]  best_idx;
		logic [DIST_W-1:0] best_dist;
		logic              exact;
	} token_t;

	// 8-bit component at a bit position; bits past the top read as zero
	function automatic logic [COMP_W-1:0] comp(input logic [PIX_W-1:0] pix,
			input logic [POS_W-1:0] pos);
		logic [PIX_W-1:0] sh;
		sh = pix >> pos;
		return sh[COMP_W-1:0];
	endfunction

	function automatic logic [COMP_W-1:0] abs_diff(input logic [COMP_W-1:0] a,
			input logic [COMP_W-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

/* rtl/nearest_palette_color_match_top.sv */
// Top level of the nearest palette color match block: input stage, cell chain, output register.
`timescale 1ns / 1ps
//
// Reverse palette lookup with nearest-color fallback.
// Slave stream: s_tuser selects the request (0 = write entry, 1 = look up pixel),
// s_tdata carries the slot and the pixel. A write loads one cell of the chain in the
// cycle it is accepted and gives no result. A lookup gives one result on the master
// stream: m_tdata is the index of the first exact match among the first entry_count
// entries, else of the first entry with the smallest red+green+blue distance;
// m_tuser flags an exact hit. An empty palette answers index 0, no hit.
// A lookup passes the input stage, each cell of the 256-cell chain in turn and the
// output register. Lookups may follow each other every cycle while the chain advances;
// a write waits until every lookup in flight has left the chain.
// The whole chain advances together; when m_tready is low with a result held, the
// chain and lookup acceptance stall. Reset clears all valid flags and loads the
// register defaults; palette entries are undefined until written.
// APB registers: 0x0 entry_count, 0x4 red, 0x8 green, 0xC blue position.

module nearest_palette_color_match_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// APB configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [npcm_pkg::ADDR_W-1:0]   paddr,
	input  logic [npcm_pkg::DATA_W-1:0]   pwdata,
	output logic [npcm_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	// Request stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [39:0]                   s_tdata,  // [7:0] entry_index, [39:8] pixel_value
	input  logic                          s_tuser,  // [0] req_type
	// Result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,  // [7:0] match_index
	output logic                          m_tuser   // [0] exact_hit
);

	npcm_pkg::cfg_t                cfg;
	logic [npcm_pkg::SLOT_W-1:0]   in_slot;
	logic [npcm_pkg::PIX_W-1:0]    in_pixel;
	logic                          s_acc;
	logic                          lookup_acc;
	logic                          write_acc;
	logic                          advance;
	logic [npcm_pkg::CNT_W-1:0]    count_sat;
	logic [npcm_pkg::INFL_W-1:0]   inflight_q;
	logic                          exit_tok;

	logic                          valid_s1;
	npcm_pkg::token_t              tok_s1;

	logic                          vld_c [0:npcm_pkg::DEPTH];
	npcm_pkg::token_t              tok_c [0:npcm_pkg::DEPTH];

	logic                          m_valid_q;
	logic [npcm_pkg::IDX_W-1:0]    m_idx_q;
	logic                          m_hit_q;

	npcm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign in_slot  = s_tdata[7:0];
	assign in_pixel = s_tdata[39:8];

	// Handshake; writes wait for the chain to drain
	assign advance    = !m_valid_q || m_tready;
	assign s_tready   = (s_tuser == npcm_pkg::REQ_LOOKUP) ? advance
	                    : (inflight_q == '0);
	assign s_acc      = s_tvalid && s_tready;
	assign lookup_acc = s_acc && (s_tuser == npcm_pkg::REQ_LOOKUP);
	assign write_acc  = s_acc && (s_tuser == npcm_pkg::REQ_WRITE)
	                    && ({1'b0, in_slot} < (npcm_pkg::SLOT_W + 1)'(npcm_pkg::DEPTH));

	assign count_sat = (cfg.entry_count > npcm_pkg::CNT_W'(npcm_pkg::DEPTH))
	                   ? npcm_pkg::CNT_W'(npcm_pkg::DEPTH) : cfg.entry_count;

	// Input stage: split the pixel into components
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= lookup_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tok_s1.pixel     <= in_pixel;
			tok_s1.red       <= npcm_pkg::comp(in_pixel, cfg.red_position);
			tok_s1.green     <= npcm_pkg::comp(in_pixel, cfg.green_position);
			tok_s1.blue      <= npcm_pkg::comp(in_pixel, cfg.blue_position);
			tok_s1.best_idx  <= '0;
			tok_s1.best_dist <= npcm_pkg::DIST_INIT;
			tok_s1.exact     <= 1'b0;
		end
	end

	assign vld_c[0] = valid_s1;
	assign tok_c[0] = tok_s1;

	// Cell chain, one cell per palette slot
	for (genvar g = 0; g < npcm_pkg::DEPTH; g++) begin : g_cell
		npcm_cell u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.cell_idx      (npcm_pkg::IDX_W'(g)),
			.active        (npcm_pkg::CNT_W'(g) < count_sat),
			.cfg           (cfg),
			.advance       (advance),
			.wr_en         (write_acc),
			.wr_idx        (in_slot[npcm_pkg::IDX_W-1:0]),
			.wr_data       (in_pixel),
			.tok_valid_in  (vld_c[g]),
			.tok_in        (tok_c[g]),
			.tok_valid_out (vld_c[g+1]),
			.tok_out       (tok_c[g+1])
		);
	end

	// Lookups between acceptance and leaving the last cell
	assign exit_tok = vld_c[npcm_pkg::DEPTH] && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (lookup_acc && !exit_tok) begin
			inflight_q <= inflight_q + 1'b1;
		end else if (!lookup_acc && exit_tok) begin
			inflight_q <= inflight_q - 1'b1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= vld_c[npcm_pkg::DEPTH];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_idx_q <= tok_c[npcm_pkg::DEPTH].best_idx;
			m_hit_q <= tok_c[npcm_pkg::DEPTH].exact;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = 8'(m_idx_q);
	assign m_tuser  = m_hit_q;

`ifndef SYNTH
	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= npcm_pkg::INFL_W'(npcm_pkg::DEPTH + 1))
		else $error("lookup count in flight exceeds chain capacity");

	a_write_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && s_tuser == npcm_pkg::REQ_WRITE) |-> (!valid_s1 && !vld_c[npcm_pkg::DEPTH]))
		else $error("palette write accepted with a lookup still in the chain");

	a_empty_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(inflight_q == '0) |-> (!valid_s1 && !vld_c[1] && !vld_c[npcm_pkg::DEPTH]))
		else $error("chain holds a lookup while the in-flight count is zero");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && m_hit_q) |-> ({1'b0, m_idx_q} < count_sat))
		else $error("exact hit reported outside the searched entries");
`endif

endmodule

/* rtl/npcm_regs.sv */
// APB configuration registers for the nearest palette color match block.
`timescale 1ns / 1ps

module npcm_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [npcm_pkg::ADDR_W-1:0]   paddr,
	input  logic [npcm_pkg::DATA_W-1:0]   pwdata,
	output logic [npcm_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output npcm_pkg::cfg_t                cfg
);

	npcm_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [1:0]     reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_sel = paddr[3:2];
	assign cfg     = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.entry_count    <= npcm_pkg::CNT_W'(256);
			cfg_q.red_position   <= npcm_pkg::POS_W'(16);
			cfg_q.green_position <= npcm_pkg::POS_W'(8);
			cfg_q.blue_position  <= '0;
		end else if (wr_en) begin
			case (reg_sel)
				npcm_pkg::REG_ENTRY_COUNT: cfg_q.entry_count <= pwdata[npcm_pkg::CNT_W-1:0];
				npcm_pkg::REG_RED_POS:     cfg_q.red_position <= pwdata[npcm_pkg::POS_W-1:0];
				npcm_pkg::REG_GREEN_POS:   cfg_q.green_position <= pwdata[npcm_pkg::POS_W-1:0];
				npcm_pkg::REG_BLUE_POS:    cfg_q.blue_position <= pwdata[npcm_pkg::POS_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		prdata = '0;
		case (reg_sel)
			npcm_pkg::REG_ENTRY_COUNT: prdata[npcm_pkg::CNT_W-1:0] = cfg_q.entry_count;
			npcm_pkg::REG_RED_POS:     prdata[npcm_pkg::POS_W-1:0] = cfg_q.red_position;
			npcm_pkg::REG_GREEN_POS:   prdata[npcm_pkg::POS_W-1:0] = cfg_q.green_position;
			npcm_pkg::REG_BLUE_POS:    prdata[npcm_pkg::POS_W-1:0] = cfg_q.blue_position;
			default:                   prdata = '0;
		endcase
	end

endmodule

/* rtl/npcm_cell.sv */
// One palette cell: holds one entry and updates the passing lookup request.
`timescale 1ns / 1ps

module npcm_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [npcm_pkg::IDX_W-1:0]    cell_idx,
	input  logic                          active,
	input  npcm_pkg::cfg_t                cfg,
	input  logic                          advance,
	input  logic                          wr_en,
	input  logic [npcm_pkg::IDX_W-1:0]    wr_idx,
	input  logic [npcm_pkg::PIX_W-1:0]    wr_data,
	input  logic                          tok_valid_in,
	input  npcm_pkg::token_t              tok_in,
	output logic                          tok_valid_out,
	output npcm_pkg::token_t              tok_out
);

	logic [npcm_pkg::PIX_W-1:0]  entry_q;
	logic                        valid_q;
	npcm_pkg::token_t            tok_q;
	npcm_pkg::token_t            tok_next;
	logic [npcm_pkg::DIST_W-1:0] sum_dist;
	logic [npcm_pkg::COMP_W-1:0] dr;
	logic [npcm_pkg::COMP_W-1:0] dg;
	logic [npcm_pkg::COMP_W-1:0] db;

	// Entry storage, loaded by broadcast write
	always_ff @(posedge clk) begin
		if (wr_en && wr_idx == cell_idx) begin
			entry_q <= wr_data;
		end
	end

	// Manhattan distance between entry and pixel components
	always_comb begin
		dr       = npcm_pkg::abs_diff(tok_in.red, npcm_pkg::comp(entry_q, cfg.red_position));
		dg       = npcm_pkg::abs_diff(tok_in.green, npcm_pkg::comp(entry_q, cfg.green_position));
		db       = npcm_pkg::abs_diff(tok_in.blue, npcm_pkg::comp(entry_q, cfg.blue_position));
		sum_dist = {2'b00, dr} + {2'b00, dg} + {2'b00, db};
	end

	// Exact hit freezes the request; otherwise keep the first strict minimum
	always_comb begin
		tok_next = tok_in;
		if (active && !tok_in.exact) begin
			if (entry_q == tok_in.pixel) begin
				tok_next.exact    = 1'b1;
				tok_next.best_idx = cell_idx;
			end else if (sum_dist < tok_in.best_dist) begin
				tok_next.best_dist = sum_dist;
				tok_next.best_idx  = cell_idx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= tok_valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tok_q <= tok_next;
		end
	end

	assign tok_valid_out = valid_q;
	assign tok_out       = tok_q;

endmodule

/* tb/tb.sv */
// Self-checking testbench for the nearest palette color match block.
`timescale 1ns / 1ps

module tb;

	typedef struct {
		logic [7:0] idx;
		logic       hit;
	} match_t;

	localparam int SETTLE_CYCLES = npcm_pkg::DEPTH + 4;

	logic                          clk;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [npcm_pkg::ADDR_W-1:0]   paddr;
	logic [npcm_pkg::DATA_W-1:0]   pwdata;
	logic [npcm_pkg::DATA_W-1:0]   prdata;
	logic                          pready;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [39:0]                   s_tdata;  // [7:0] entry_index, [39:8] pixel_value
	logic                          s_tuser;  // [0] req_type
	logic                          m_tvalid;
	logic                          m_tready;
	logic [7:0]                    m_tdata;  // [7:0] match_index
	logic                          m_tuser;  // [0] exact_hit

	// Mirror of the block state as seen through accepted requests
	logic [31:0]                   palette_mirror [npcm_pkg::DEPTH];
	npcm_pkg::cfg_t                settings_mirror;
	match_t                        expected_matches [$];

	int                            send_idle_pct;
	int                            recv_stall_pct;
	int                            hold_left;
	int                            mismatches;

	nearest_palette_color_match_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Hard stop in case the block hangs
	initial begin
		#(64'd20_000_000);
		$display("%0t: timeout, %0d results still outstanding", $time, expected_matches.size());
		$display("CHECK FAILED");
		$finish;
	end

	// ---------------------------------------------------------------- prediction

	function automatic logic [7:0] chan(input logic [31:0] pix, input logic [4:0] pos);
		return 8'(pix >> pos);
	endfunction

	// Absolute difference of one color channel
	function automatic int spread(input logic [31:0] a, input logic [31:0] b,
			input logic [4:0] pos);
		int ca;
		int cb;
		ca = int'(chan(a, pos));
		cb = int'(chan(b, pos));
		return (ca > cb) ? ca - cb : cb - ca;
	endfunction

	// Entries searched; counts past the table saturate
	function automatic int search_span();
		return (settings_mirror.entry_count > npcm_pkg::DEPTH) ? npcm_pkg::DEPTH
			: int'(settings_mirror.entry_count);
	endfunction

	function automatic match_t predict_match(input logic [31:0] pix);
		match_t res;
		int     span;
		int     lowest;
		int     total;
		int     i;
		res.idx = '0;
		res.hit = 1'b0;
		lowest  = 1 << 20;
		span    = search_span();
		for (i = 0; i < span; i++) begin
			if (palette_mirror[i] == pix) begin
				res.idx = 8'(i);
				res.hit = 1'b1;
				return res;
			end
			total = spread(pix, palette_mirror[i], settings_mirror.red_position)
				+ spread(pix, palette_mirror[i], settings_mirror.green_position)
				+ spread(pix, palette_mirror[i], settings_mirror.blue_position);
			// strict compare keeps the lowest index on ties
			if (total < lowest) begin
				lowest  = total;
				res.idx = 8'(i);
			end
		end
		return res;
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	// Bytes mostly from a small set of corner values, else random, so ties and duplicates show up often
	function automatic logic [31:0] random_color();
		logic [31:0] c;
		int          k;
		for (k = 0; k < 4; k++) begin
			case ($urandom_range(5))
				0:       c[k*8 +: 8] = 8'h00;
				1:       c[k*8 +: 8] = 8'h01;
				2:       c[k*8 +: 8] = 8'h80;
				3:       c[k*8 +: 8] = 8'hFF;
				default: c[k*8 +: 8] = 8'($urandom);
			endcase
		end
		return c;
	endfunction

	// Lookup pixel: a table entry, a one-bit neighbor of one, a corner color or noise
	function automatic logic [31:0] pick_pixel();
		logic [31:0] base;
		int          span;
		span = search_span();
		base = (span > 0) ? palette_mirror[$urandom_range(span - 1)] : $urandom;
		case ($urandom_range(3))
			0:       return base;
			1:       return base ^ (32'd1 << $urandom_range(31));
			2:       return random_color();
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [4:0] pick_position();
		case ($urandom_range(3))
			0:       return 5'd24;
			1:       return 5'd0;
			default: return 5'($urandom_range(31));
		endcase
	endfunction

	// One request on the slave stream; tvalid stays high on return
	task automatic send_request(input logic kind, input logic [7:0] slot,
			input logic [31:0] pix);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {pix, slot};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (kind == npcm_pkg::REQ_WRITE)
			palette_mirror[slot] = pix;
		else
			expected_matches.push_back(predict_match(pix));
	endtask

	task automatic write_entry(input logic [7:0] slot, input logic [31:0] pix);
		send_request(npcm_pkg::REQ_WRITE, slot, pix);
	endtask

	task automatic lookup(input logic [31:0] pix);
		send_request(npcm_pkg::REQ_LOOKUP, 8'($urandom), pix);
	endtask

	// Stop sending and wait for every outstanding result
	task automatic pause_until_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_matches.size() != 0)
			@(posedge clk);
	endtask

	task automatic apb_cycle(input logic wr, input logic [1:0] reg_sel,
			input logic [31:0] wdata, output logic [31:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {reg_sel, 2'b00};
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Register write with read-back
	task automatic write_register(input logic [1:0] reg_sel, input logic [31:0] value);
		logic [31:0] readback;
		logic [31:0] mask;
		apb_cycle(1'b1, reg_sel, value, readback);
		apb_cycle(1'b0, reg_sel, 32'd0, readback);
		mask = (reg_sel == npcm_pkg::REG_ENTRY_COUNT) ? 32'h1FF : 32'h1F;
		if ((readback & mask) != (value & mask)) begin
			$display("%0t: register %0d read back: expected %0h, actual %0h",
				$time, reg_sel, value & mask, readback & mask);
			mismatches++;
		end
		case (reg_sel)
			npcm_pkg::REG_ENTRY_COUNT: settings_mirror.entry_count    = value[8:0];
			npcm_pkg::REG_RED_POS:     settings_mirror.red_position   = value[4:0];
			npcm_pkg::REG_GREEN_POS:   settings_mirror.green_position = value[4:0];
			npcm_pkg::REG_BLUE_POS:    settings_mirror.blue_position  = value[4:0];
			default: ;
		endcase
	endtask

	// New settings only with the block idle; writes give no result, so let the chain settle
	task automatic reconfigure(input int count, input int red, input int green, input int blue);
		pause_until_drained();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		write_register(npcm_pkg::REG_ENTRY_COUNT, 32'(count));
		write_register(npcm_pkg::REG_RED_POS, 32'(red));
		write_register(npcm_pkg::REG_GREEN_POS, 32'(green));
		write_register(npcm_pkg::REG_BLUE_POS, 32'(blue));
	endtask

	// ---------------------------------------------------------------- tests

	// Small palette: exact hits first and last, ties, empty and one-entry palettes,
	// channels at the top of the word and channels that overlap
	task automatic test_directed();
		reconfigure(4, 16, 8, 0);
		write_entry(8'd0, 32'h00102030);
		write_entry(8'd1, 32'hAA102031);
		write_entry(8'd2, 32'h55102031);
		write_entry(8'd3, 32'hFFFFFFFF);
		lookup(32'hFFFFFFFF);
		lookup(32'h00102030);
		lookup(32'h00102031);
		lookup(32'h00000000);
		lookup(32'h55102031);
		lookup(32'h7F7F7F7F);
		reconfigure(0, 16, 8, 0);
		lookup(32'h00102030);
		reconfigure(1, 16, 8, 0);
		lookup(32'hFFFFFFFF);
		reconfigure(4, 31, 25, 24);
		lookup(32'h80000000);
		lookup(32'hFFFFFFFE);
		reconfigure(4, 0, 0, 0);
		lookup(32'h00000031);
	endtask

	// Load every slot, then search the whole table with a saturating count
	task automatic test_full_table();
		int n;
		for (n = 0; n < npcm_pkg::DEPTH; n++)
			write_entry(8'(n), random_color());
		reconfigure(511, 16, 8, 0);
		for (n = 0; n < 15; n++)
			lookup(pick_pixel());
		reconfigure(256, 0, 24, 31);
		for (n = 0; n < 15; n++)
			lookup(pick_pixel());
	endtask

	task automatic test_random_traffic(input int sender_idle, input int recv_stall,
			input int n_items);
		int n;
		int count;
		send_idle_pct  = sender_idle;
		recv_stall_pct = recv_stall;
		case ($urandom_range(5))
			0:       count = 0;
			1:       count = 1;
			2:       count = 256;
			3:       count = $urandom_range(257, 511);
			default: count = $urandom_range(2, 255);
		endcase
		reconfigure(count, pick_position(), pick_position(), pick_position());
		for (n = 0; n < n_items; n++) begin
			if ($urandom_range(49) == 0)
				pause_until_drained();
			if ($urandom_range(3) == 0)
				write_entry(8'($urandom), random_color());
			else
				lookup(pick_pixel());
		end
	endtask

	// Receiver holds off while lookups keep coming, so the frozen chain refuses
	// them; a write near the end must wait for the stalled chain to drain
	task automatic test_output_backpressure();
		int n;
		send_idle_pct  = 80;
		recv_stall_pct = 0;
		reconfigure(256, 16, 8, 0);
		@(negedge clk);
		hold_left = 600;
		for (n = 0; n < 80; n++) begin
			if (n == 70)
				write_entry(8'($urandom), random_color());
			lookup(pick_pixel());
		end
		pause_until_drained();
	endtask

	// ---------------------------------------------------------------- result side

	// Receiver ready, with a counted hold-off on demand
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Compare each result with the oldest prediction
	always @(posedge clk) begin
		match_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_matches.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual index %0d hit %0b",
					$time, m_tdata, m_tuser);
				mismatches++;
			end else begin
				want = expected_matches.pop_front();
				if (m_tdata !== want.idx) begin
					$display("%0t: match_index: expected %0d, actual %0d",
						$time, want.idx, m_tdata);
					mismatches++;
				end
				if (m_tuser !== want.hit) begin
					$display("%0t: exact_hit: expected %0b, actual %0b",
						$time, want.hit, m_tuser);
					mismatches++;
				end
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		int n;
		arst_n          = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		s_tvalid        = 1'b0;
		s_tdata         = '0;
		s_tuser         = npcm_pkg::REQ_WRITE;
		m_tready        = 1'b0;
		hold_left       = 0;
		mismatches      = 0;
		send_idle_pct   = 23;
		recv_stall_pct  = 68;
		settings_mirror = '{entry_count: 9'd256, red_position: 5'd16,
			green_position: 5'd8, blue_position: 5'd0};
		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_full_table();
		test_random_traffic(23, 68, 70);
		test_random_traffic(68, 23, 70);
		test_random_traffic(0, 0, 70);
		test_output_backpressure();

		@(negedge clk);
		s_tvalid <= 1'b0;
		for (n = 0; n < 200000 && expected_matches.size() != 0; n++)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		if (expected_matches.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, expected_matches.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
